// File: rtl/b2a_pkg.sv
// ----------------------------------------------------------------------------
// b2a_pkg
// Shared types and constants of the binary to ASCII number formatter.
// ----------------------------------------------------------------------------
package b2a_pkg;

  localparam int ValW         = 32;
  localparam int DigW         = 4;
  localparam int NumDig       = 10;
  localparam int BcdW         = NumDig * DigW;
  localparam int CharW        = 7;
  localparam int CntW         = 4;
  localparam int PassPerStage = 4;
  localparam int NumStages    = ValW / PassPerStage;

  // format commands
  localparam logic [2:0] CMD_DEC8   = 3'd0;
  localparam logic [2:0] CMD_DEC16  = 3'd1;
  localparam logic [2:0] CMD_SDEC16 = 3'd2;
  localparam logic [2:0] CMD_DEC32  = 3'd3;
  localparam logic [2:0] CMD_HEX8   = 3'd4;
  localparam logic [2:0] CMD_HEX16  = 3'd5;
  localparam logic [2:0] CMD_HEX32  = 3'd6;

  localparam logic [CharW-1:0] ASCII_ZERO  = 7'h30;
  localparam logic [CharW-1:0] ASCII_NINE  = 7'h39;
  localparam logic [CharW-1:0] ASCII_MINUS = 7'h2D;
  localparam logic [CharW-1:0] HEX_GAP     = 7'd7;

  typedef logic [BcdW-1:0] bcd_t;

  // one item on its way through the conversion pipeline
  typedef struct packed {
    logic [2:0]      cmd;
    logic            neg;
    logic [ValW-1:0] bin;
    logic [ValW-1:0] raw;
    bcd_t            bcd;
  } b2a_stage_t;

endpackage

// File: rtl/b2a_bcd_pipe.sv
// ----------------------------------------------------------------------------
// b2a_bcd_pipe
// Shift-and-double BCD conversion, four bit passes per pipeline stage.
// ----------------------------------------------------------------------------
module b2a_bcd_pipe (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  b2a_pkg::b2a_stage_t in_stage,
  input  logic               adv,
  output logic               out_vld,
  output b2a_pkg::b2a_stage_t out_stage
);
  import b2a_pkg::*;

  // one pass: double every digit, carry into the next digit up, shift in a bit
  function automatic bcd_t dd_pass(bcd_t bcd, logic bit_in);
    bcd_t            res;
    logic [DigW-1:0] d;
    logic [DigW:0]   dbl;
    logic [DigW-1:0] ones;
    logic            cin;
    res = '0;
    cin = bit_in;
    for (int j = 0; j < NumDig; j++) begin
      d    = bcd[j*DigW +: DigW];
      dbl  = {d, 1'b0};
      ones = (d >= 4'd5) ? DigW'(dbl - 5'd10) : dbl[DigW-1:0];
      res[j*DigW +: DigW] = ones | {3'b000, cin};
      cin  = (d >= 4'd5);
    end
    return res;
  endfunction

  function automatic b2a_stage_t pass_group(b2a_stage_t s);
    b2a_stage_t t;
    t = s;
    for (int p = 0; p < PassPerStage; p++) begin
      t.bcd = dd_pass(t.bcd, t.bin[ValW-1]);
      t.bin = {t.bin[ValW-2:0], 1'b0};
    end
    return t;
  endfunction

  b2a_stage_t           st_r [0:NumStages];
  logic [NumStages:0]   vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NumStages-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0] <= in_stage;
      for (int k = 1; k <= NumStages; k++) begin
        st_r[k] <= pass_group(st_r[k-1]);
      end
    end
  end

  assign out_vld   = vld_r[NumStages];
  assign out_stage = st_r[NumStages];

endmodule

// File: rtl/binary_to_ascii_number_formatter_core.sv
// ----------------------------------------------------------------------------
// binary_to_ascii_number_formatter_core
// Formats a 32-bit value as a run of ASCII decimal or hex characters.
// ----------------------------------------------------------------------------
// channel  ports                               payload
// in       in_tvalid  in_tready  in_tdata[39:0]  cmd, value
// out      out_tvalid out_tready out_tdata[7:0]  ascii_char; out_tlast = last
//
// an item passes an input register, eight conversion stages of four bit passes
// each and then the output register before its first character is offered
// one character leaves per cycle while out_tready is high; an item of n characters
// holds the output until all n are taken, and the next item loads in the cycle its last one is taken
// an item with an unused command is taken and gives no characters
// synchronous active-low reset empties the pipeline and the output stage
// ----------------------------------------------------------------------------
module binary_to_ascii_number_formatter_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [39:0] in_tdata,   // [2:0] cmd, [34:3] value, rest zero
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [6:0] ascii_char, [7] zero
  output logic       out_tlast
);
  import b2a_pkg::*;

  typedef logic [NumDig-1:0][CharW-1:0] line_t;

  function automatic logic [CharW-1:0] hex_char(logic [3:0] n);
    logic [CharW-1:0] ch;
    ch = {3'b000, n} + ASCII_ZERO;
    if (ch > ASCII_NINE) ch = ch + HEX_GAP;
    return ch;
  endfunction

  logic [2:0]      cmd_in;
  logic [ValW-1:0] val_in;
  logic [15:0]     mag;
  b2a_stage_t      stage_in;
  logic            pipe_in_vld;
  logic            pipe_vld;
  b2a_stage_t      pipe_out;
  logic            adv;
  logic            take;
  logic            last_char;

  line_t           fmt_line;
  logic [CntW-1:0] fmt_cnt;

  line_t           chr_r, chr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;

  assign cmd_in = in_tdata[2:0];
  assign val_in = in_tdata[34:3];
  assign mag    = in_tdata[18] ? (~val_in[15:0] + 16'd1) : val_in[15:0];

  always_comb begin
    stage_in     = '0;
    stage_in.cmd = cmd_in;
    stage_in.raw = val_in;
    case (cmd_in)
      CMD_DEC8:   stage_in.bin = {24'b0, val_in[7:0]};
      CMD_DEC16:  stage_in.bin = {16'b0, val_in[15:0]};
      CMD_SDEC16: begin
        stage_in.neg = val_in[15];
        stage_in.bin = {16'b0, mag};
      end
      default:    stage_in.bin = val_in;
    endcase
  end

  assign pipe_in_vld = in_tvalid && (cmd_in <= CMD_HEX32);

  b2a_bcd_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (pipe_in_vld),
    .in_stage  (stage_in),
    .adv       (adv),
    .out_vld   (pipe_vld),
    .out_stage (pipe_out)
  );

  // character line of the item leaving the pipeline, first character at index 0
  always_comb begin
    fmt_line = '0;
    fmt_cnt  = '0;
    case (pipe_out.cmd)
      CMD_DEC8: begin
        for (int i = 0; i < 3; i++)
          fmt_line[i] = ASCII_ZERO | {3'b000, pipe_out.bcd[DigW*(2-i) +: DigW]};
        fmt_cnt = 4'd3;
      end
      CMD_DEC16: begin
        for (int i = 0; i < 5; i++)
          fmt_line[i] = ASCII_ZERO | {3'b000, pipe_out.bcd[DigW*(4-i) +: DigW]};
        fmt_cnt = 4'd5;
      end
      CMD_SDEC16: begin
        if (pipe_out.neg) begin
          fmt_line[0] = ASCII_MINUS;
          for (int i = 0; i < 5; i++)
            fmt_line[i+1] = ASCII_ZERO | {3'b000, pipe_out.bcd[DigW*(4-i) +: DigW]};
          fmt_cnt = 4'd6;
        end else begin
          for (int i = 0; i < 5; i++)
            fmt_line[i] = ASCII_ZERO | {3'b000, pipe_out.bcd[DigW*(4-i) +: DigW]};
          fmt_cnt = 4'd5;
        end
      end
      CMD_DEC32: begin
        for (int i = 0; i < NumDig; i++)
          fmt_line[i] = ASCII_ZERO | {3'b000, pipe_out.bcd[DigW*(NumDig-1-i) +: DigW]};
        fmt_cnt = 4'd10;
      end
      CMD_HEX8: begin
        for (int i = 0; i < 2; i++)
          fmt_line[i] = hex_char(pipe_out.raw[4*(1-i) +: 4]);
        fmt_cnt = 4'd2;
      end
      CMD_HEX16: begin
        for (int i = 0; i < 4; i++)
          fmt_line[i] = hex_char(pipe_out.raw[4*(3-i) +: 4]);
        fmt_cnt = 4'd4;
      end
      CMD_HEX32: begin
        for (int i = 0; i < 8; i++)
          fmt_line[i] = hex_char(pipe_out.raw[4*(7-i) +: 4]);
        fmt_cnt = 4'd8;
      end
      default: begin
        fmt_line = '0;
        fmt_cnt  = '0;
      end
    endcase
  end

  assign last_char = (cnt_r == 4'd1);
  // output stage free now or after this cycle's last character
  assign take      = !busy_r || (out_tready && last_char);
  assign adv       = !pipe_vld || take;
  assign in_tready = adv;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    chr_nxt  = chr_r;
    if (take) begin
      busy_nxt = pipe_vld;
      cnt_nxt  = fmt_cnt;
      chr_nxt  = fmt_line;
    end else if (out_tready) begin
      cnt_nxt  = cnt_r - 4'd1;
      chr_nxt  = chr_r >> CharW;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chr_r <= chr_nxt;
  end

  assign out_tvalid = busy_r;
  assign out_tdata  = {1'b0, chr_r[0]};
  assign out_tlast  = last_char;

endmodule

// File: rtl/b2a_checker.sv
// ----------------------------------------------------------------------------
// b2a_checker
// Port-level checks of the number formatter, bound to the top level.
// ----------------------------------------------------------------------------
module b2a_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [39:0] in_tdata,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata))
    else $error("input item changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output item dropped or changed while stalled");

  // only digits, uppercase hex letters and the minus sign are ever sent
  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata >= 8'h30 && out_tdata <= 8'h39) ||
                   (out_tdata >= 8'h41 && out_tdata <= 8'h46) ||
                   (out_tdata == 8'h2D))
    else $error("character outside the output set");

  // a sign never closes a run
  a_minus_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata == 8'h2D |-> !out_tlast)
    else $error("minus sign marked as last");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind binary_to_ascii_number_formatter_core b2a_checker u_b2a_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the number formatter by streaming format commands with values into
// it and comparing every character that leaves, and its last flag, against
// characters predicted by plain division and nibble slicing. Directed edge
// values come first, then random phases with and without idling on either
// side, a long output hold-off and pauses until the output has drained.
// ----------------------------------------------------------------------------
module tb_top;
  import b2a_pkg::*;

  localparam int         CLK_PERIOD  = 10;
  localparam int         RESET_TICKS = 5;
  localparam int         SETTLE      = 16;    // a little more than the pipeline depth
  localparam int         HOLD_TICKS  = 300;
  localparam int         QUIET_LIMIT = 2000;
  localparam logic [2:0] CMD_UNUSED  = 3'd7;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             last;
  } char_item_t;

  class char_run_checker;
    char_item_t awaited_chars[$];
    int         error_count = 0;

    function void add_char(logic [CharW-1:0] ch);
      char_item_t c;
      c.ch   = ch;
      c.last = 1'b0;
      awaited_chars.push_back(c);
    endfunction

    // fixed number of decimal digits, leading zeros kept
    function void add_decimal(logic [31:0] v, int ndig);
      logic [CharW-1:0] digs[$];
      for (int i = 0; i < ndig; i++) begin
        digs.push_front(ASCII_ZERO + 7'(v % 32'd10));
        v = v / 32'd10;
      end
      foreach (digs[i]) add_char(digs[i]);
    endfunction

    function void add_hex(logic [31:0] v, int ndig);
      logic [3:0] nib;
      for (int i = ndig - 1; i >= 0; i--) begin
        nib = v[i*4 +: 4];
        if (nib < 4'd10) add_char(ASCII_ZERO + 7'(nib));
        else add_char(ASCII_ZERO + 7'(nib) + HEX_GAP);
      end
    endfunction

    function void note_number(logic [2:0] cmd, logic [31:0] value);
      int         start;
      logic [15:0] mag;
      start = awaited_chars.size();
      case (cmd)
        CMD_DEC8:   add_decimal({24'd0, value[7:0]}, 3);
        CMD_DEC16:  add_decimal({16'd0, value[15:0]}, 5);
        CMD_SDEC16: begin
          mag = value[15:0];
          if (value[15]) begin
            add_char(ASCII_MINUS);
            mag = 16'd0 - value[15:0];
          end
          add_decimal({16'd0, mag}, 5);
        end
        CMD_DEC32:  add_decimal(value, 10);
        CMD_HEX8:   add_hex(value, 2);
        CMD_HEX16:  add_hex(value, 4);
        CMD_HEX32:  add_hex(value, 8);
        default: ;  // unused command gives nothing
      endcase
      if (awaited_chars.size() > start)
        awaited_chars[awaited_chars.size() - 1].last = 1'b1;
    endfunction

    function void check_char(logic [7:0] data, logic last);
      char_item_t exp;
      if (awaited_chars.size() == 0) begin
        $error("unexpected character %h (last %b)", data[CharW-1:0], last);
        error_count++;
        return;
      end
      exp = awaited_chars.pop_front();
      if (data[CharW-1:0] !== exp.ch) begin
        $error("ascii_char mismatch: expected %h, actual %h", exp.ch, data[CharW-1:0]);
        error_count++;
      end
      if (last !== exp.last) begin
        $error("last mismatch: expected %b, actual %b", exp.last, last);
        error_count++;
      end
    endfunction

    function int pending();
      return awaited_chars.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;     // [2:0] cmd, [34:3] value, rest zero
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;         // [6:0] ascii_char, [7] zero
  logic        out_tlast;

  char_run_checker board = new();
  int              send_idle_pct = 0;
  int              recv_stall_pct = 0;
  bit              hold_request = 1'b0;
  int              quiet_cycles = 0;

  binary_to_ascii_number_formatter_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // receiver: random stalls, or one long hold-off when asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_TICKS) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_char(out_tdata, out_tlast);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  // called at a rising edge; returns at the edge where the item is taken
  task automatic send_item(input logic [2:0] cmd, input logic [31:0] value);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'd0, value, cmd};
    do @(posedge clk); while (!in_tready);
    board.note_number(cmd, value);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.pending() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 15);
      2: return $urandom() >> $urandom_range(0, 31);
      3: return {16'($urandom()), 16'h8000 | 16'($urandom_range(0, 255))};
      4: return 32'hFFFF_FFFF - $urandom_range(0, 15);
      default: return 32'($urandom_range(0, 255)) << ($urandom_range(0, 3) * 8);
    endcase
  endfunction

  // count covers only items that produce characters
  task automatic send_random(input int count);
    int         done;
    logic [2:0] cmd;
    done = 0;
    while (done < count) begin
      if ($urandom_range(0, 15) == 0) cmd = CMD_UNUSED;
      else cmd = 3'($urandom_range(CMD_DEC8, CMD_HEX32));
      send_item(cmd, pick_value());
      if (cmd != CMD_UNUSED) done++;
    end
  endtask

  initial begin
    int idle_pcts[4];
    int stall_pcts[4];
    idle_pcts  = '{0, 69, 0, 38};
    stall_pcts = '{0, 0, 69, 38};

    repeat (RESET_TICKS) @(posedge clk);
    rst_n <= 1'b1;

    send_item(CMD_DEC8,   32'h0000_0000);
    send_item(CMD_DEC8,   32'hFFFF_FFFF);
    send_item(CMD_DEC8,   32'h0000_0064);
    send_item(CMD_DEC16,  32'h0000_0000);
    send_item(CMD_DEC16,  32'hA5A5_FFFF);
    send_item(CMD_DEC16,  32'h0000_2710);
    send_item(CMD_SDEC16, 32'h0000_0000);
    send_item(CMD_SDEC16, 32'hFFFF_7FFF);
    send_item(CMD_SDEC16, 32'h0000_8000);
    send_item(CMD_SDEC16, 32'h0000_FFFF);
    send_item(CMD_SDEC16, 32'h1234_FF85);
    send_item(CMD_DEC32,  32'h0000_0000);
    send_item(CMD_DEC32,  32'hFFFF_FFFF);
    send_item(CMD_DEC32,  32'h8000_0000);
    send_item(CMD_DEC32,  32'h3B9A_CA00);
    send_item(CMD_HEX8,   32'h0000_0000);
    send_item(CMD_HEX8,   32'hFFFF_FFFF);
    send_item(CMD_HEX8,   32'h0000_00A5);
    send_item(CMD_HEX16,  32'h1234_ABCD);
    send_item(CMD_HEX16,  32'hFFFF_0000);
    send_item(CMD_HEX32,  32'h0123_4567);
    send_item(CMD_HEX32,  32'h89AB_CDEF);
    send_item(CMD_UNUSED, 32'hFFFF_FFFF);
    send_item(CMD_UNUSED, 32'h0000_0000);
    send_item(CMD_HEX32,  32'h0000_0000);
    drain();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_pcts[p];
      recv_stall_pct = stall_pcts[p];
      send_random(42);
      drain();
    end

    // output held off while items keep coming, so the input backs up
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 1'b1;
    send_random(25);
    drain();

    if (board.error_count == 0 && board.pending() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
